// ===== design/lcpc_pkg.sv =====
// package for the pose controller: payload structs, inter-stage structs,
// register indexes, reset values and fixed-point constants. no dependencies
package lcpc_pkg;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [15:0] target_yaw;
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic signed [31:0] current_z;
    logic signed [15:0] current_yaw;
    logic               close_loop;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] yaw_rate;
    logic               arrived;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_GAIN_XY,
    REG_GAIN_Z_YAW,
    REG_TOL_XY,
    REG_TOL_Z_YAW,
    REG_LIM_XY,
    REG_LIM_Z,
    REG_LIM_YAW
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] gain_xy;
    logic [31:0] gain_z_yaw;
    logic [31:0] tol_xy;
    logic [31:0] tol_z_yaw;
    logic [31:0] lim_xy;
    logic [31:0] lim_z;
    logic [31:0] lim_yaw;
  } cfg_t;

  localparam logic [31:0] RST_GAIN = 32'd16777472;
  localparam logic [31:0] RST_TOL_XY = 32'd1703962;
  localparam logic [31:0] RST_TOL_Z_YAW = 32'd1704346;
  localparam logic [31:0] RST_LIM = 32'd16842496;

  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032874;
  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

  localparam int CORDIC_STEPS = 16;
  localparam int LOG_BITS = 16;
  localparam int LANES = 4;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_YAW = 3;

  typedef struct packed {
    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic signed [32:0] ez;
    logic signed [16:0] eyaw;
    logic signed [34:0] ang;
    logic               flip;
    logic               arrived;
  } front_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    front_t             f;
  } cst_t;

  typedef struct packed {
    logic signed [34:0] ex;
    logic signed [34:0] ey;
    logic signed [34:0] ez;
    logic signed [34:0] eyaw;
    logic               arrived;
  } err_t;

  function automatic logic signed [34:0] atan_q30(input int k);
    logic signed [34:0] r;
    case (k)
      0:       r = 35'sd843314857;
      1:       r = 35'sd497837829;
      2:       r = 35'sd263043837;
      3:       r = 35'sd133525159;
      4:       r = 35'sd67021687;
      5:       r = 35'sd33543516;
      6:       r = 35'sd16775851;
      7:       r = 35'sd8388437;
      8:       r = 35'sd4194283;
      9:       r = 35'sd2097149;
      10:      r = 35'sd1048575;
      11:      r = 35'sd524287;
      12:      r = 35'sd262143;
      13:      r = 35'sd131071;
      14:      r = 35'sd65535;
      15:      r = 35'sd32767;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/lcpc_front.sv =====
// front end: pose errors, yaw wrap, arrival test and cordic angle reduction
// two register stages; uses lcpc_pkg
module lcpc_front import lcpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_vld_i,
  output logic     in_rdy_o,
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  output logic     out_vld_o,
  input  logic     out_rdy_i,
  output front_t   out_data_o
);

  localparam int NS = 2;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  logic signed [32:0] ex1_q, ey1_q, ez1_q, ex1_d, ey1_d, ez1_d;
  logic signed [16:0] eyaw1_q, eyaw1_d, dyaw;
  logic signed [34:0] ang1_q, ang1_d, ang0;
  logic               cl1_q;
  front_t             f2_q, f2_d;
  logic [32:0]        mx, my, mz;
  logic [16:0]        myaw;

  always_comb begin
    en[NS] = out_rdy_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_rdy_o = en[0];
  assign out_vld_o = vld_q[NS-1];
  assign out_data_o = f2_q;

  always_comb begin
    ex1_d = $signed({in_data_i.target_x[31], in_data_i.target_x})
          - $signed({in_data_i.current_x[31], in_data_i.current_x});
    ey1_d = $signed({in_data_i.target_y[31], in_data_i.target_y})
          - $signed({in_data_i.current_y[31], in_data_i.current_y});
    ez1_d = $signed({in_data_i.target_z[31], in_data_i.target_z})
          - $signed({in_data_i.current_z[31], in_data_i.current_z});
    dyaw = $signed({in_data_i.target_yaw[15], in_data_i.target_yaw})
         - $signed({in_data_i.current_yaw[15], in_data_i.current_yaw});
    if (dyaw >= PI_Q13) begin
      eyaw1_d = dyaw - TWO_PI_Q13;
    end else if (dyaw < -PI_Q13) begin
      eyaw1_d = dyaw + TWO_PI_Q13;
    end else begin
      eyaw1_d = dyaw;
    end
    ang0 = $signed({{2{in_data_i.current_yaw[15]}}, in_data_i.current_yaw, 17'b0});
    if (ang0 >= PI_Q30) begin
      ang1_d = ang0 - TWO_PI_Q30;
    end else if (ang0 < -PI_Q30) begin
      ang1_d = ang0 + TWO_PI_Q30;
    end else begin
      ang1_d = ang0;
    end
  end

  always_comb begin
    mx = ex1_q[32] ? 33'(-ex1_q) : 33'(ex1_q);
    my = ey1_q[32] ? 33'(-ey1_q) : 33'(ey1_q);
    mz = ez1_q[32] ? 33'(-ez1_q) : 33'(ez1_q);
    myaw = eyaw1_q[16] ? 17'(-eyaw1_q) : 17'(eyaw1_q);
    f2_d.ex = ex1_q;
    f2_d.ey = ey1_q;
    f2_d.ez = ez1_q;
    f2_d.eyaw = eyaw1_q;
    f2_d.arrived = cl1_q ||
      ((mx < {9'b0, cfg_i.tol_xy[31:16], 8'b0}) &&
       (my < {9'b0, cfg_i.tol_xy[15:0], 8'b0}) &&
       (mz < {9'b0, cfg_i.tol_z_yaw[31:16], 8'b0}) &&
       (myaw < {1'b0, cfg_i.tol_z_yaw[15:0]}));
    if (ang1_q > HALF_PI_Q30) begin
      f2_d.ang = ang1_q - PI_Q30;
      f2_d.flip = 1'b1;
    end else if (ang1_q < -HALF_PI_Q30) begin
      f2_d.ang = ang1_q + PI_Q30;
      f2_d.flip = 1'b1;
    end else begin
      f2_d.ang = ang1_q;
      f2_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_vld_i;
      if (en[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ex1_q <= ex1_d;
      ey1_q <= ey1_d;
      ez1_q <= ez1_d;
      eyaw1_q <= eyaw1_d;
      ang1_q <= ang1_d;
      cl1_q <= in_data_i.close_loop;
    end
    if (en[1]) begin
      f2_q <= f2_d;
    end
  end

endmodule

// ===== design/lcpc_cordic.sv =====
// sine and cosine of the measured yaw: one cordic rotation per stage
// sixteen register stages; uses lcpc_pkg
module lcpc_cordic import lcpc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_vld_i,
  output logic   in_rdy_o,
  input  front_t in_data_i,
  output logic   out_vld_o,
  input  logic   out_rdy_i,
  output cst_t   out_data_o
);

  localparam int NS = CORDIC_STEPS;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;
  cst_t          st_q [NS];

  always_comb begin
    en[NS] = out_rdy_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_rdy_o = en[0];
  assign out_vld_o = vld_q[NS-1];
  assign out_data_o = st_q[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_step
    cst_t               cur, nxt;
    logic signed [32:0] dx, dy;

    if (k == 0) begin : g_first
      always_comb begin
        cur.x = CORDIC_K_Q30;
        cur.y = '0;
        cur.f = in_data_i;
      end
    end else begin : g_next
      assign cur = st_q[k-1];
    end

    always_comb begin
      dx = cur.y >>> k;
      dy = cur.x >>> k;
      nxt = cur;
      if (!cur.f.ang[34]) begin
        nxt.x = cur.x - dx;
        nxt.y = cur.y + dy;
        nxt.f.ang = cur.f.ang - atan_q30(k);
      end else begin
        nxt.x = cur.x + dx;
        nxt.y = cur.y - dy;
        nxt.f.ang = cur.f.ang + atan_q30(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= (k == 0) ? in_vld_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

endmodule

// ===== design/lcpc_rotate.sv =====
// body-frame rotation of the x-y error: round sin/cos, four products, sums
// three register stages; uses lcpc_pkg
module lcpc_rotate import lcpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_vld_i,
  output logic in_rdy_o,
  input  cst_t in_data_i,
  output logic out_vld_o,
  input  logic out_rdy_i,
  output err_t out_data_o
);

  localparam int NS = 3;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  logic signed [33:0] xe, ye, xr, yr;
  logic signed [25:0] c1_q, s1_q;
  logic signed [32:0] ex1_q, ey1_q, ez1_q, ez2_q;
  logic signed [16:0] eyaw1_q, eyaw2_q;
  logic               arr1_q, arr2_q;
  logic signed [58:0] pcx_q, psy_q, pcy_q, psx_q, pcx_d, psy_d, pcy_d, psx_d;
  logic signed [59:0] sx, sy;
  err_t               out_q, out_d;

  always_comb begin
    en[NS] = out_rdy_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_rdy_o = en[0];
  assign out_vld_o = vld_q[NS-1];
  assign out_data_o = out_q;

  // round to q.24, undoing the half-turn fold
  always_comb begin
    xe = {in_data_i.x[32], in_data_i.x};
    ye = {in_data_i.y[32], in_data_i.y};
    xr = in_data_i.f.flip ? (~xe + 34'sd33) : (xe + 34'sd32);
    yr = in_data_i.f.flip ? (~ye + 34'sd33) : (ye + 34'sd32);
  end

  assign pcx_d = c1_q * ex1_q;
  assign psy_d = s1_q * ey1_q;
  assign pcy_d = c1_q * ey1_q;
  assign psx_d = s1_q * ex1_q;

  always_comb begin
    sx = {pcx_q[58], pcx_q} + {psy_q[58], psy_q} + 60'sd8388608;
    sy = {pcy_q[58], pcy_q} - {psx_q[58], psx_q} + 60'sd8388608;
    out_d.ex = sx[58:24];
    out_d.ey = sy[58:24];
    out_d.ez = $signed({{2{ez2_q[32]}}, ez2_q});
    out_d.eyaw = $signed({{15{eyaw2_q[16]}}, eyaw2_q, 3'b0});
    out_d.arrived = arr2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_vld_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_q <= xr[31:6];
      s1_q <= yr[31:6];
      ex1_q <= in_data_i.f.ex;
      ey1_q <= in_data_i.f.ey;
      ez1_q <= in_data_i.f.ez;
      eyaw1_q <= in_data_i.f.eyaw;
      arr1_q <= in_data_i.f.arrived;
    end
    if (en[1]) begin
      pcx_q <= pcx_d;
      psy_q <= psy_d;
      pcy_q <= pcy_d;
      psx_q <= psx_d;
      ez2_q <= ez1_q;
      eyaw2_q <= eyaw1_q;
      arr2_q <= arr1_q;
    end
    if (en[2]) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/lcpc_axis.sv =====
// four command lanes: log10(|e|+1) by squaring, gain, rounding, clamp
// twenty-three register stages, last one is the output register; uses lcpc_pkg
module lcpc_axis import lcpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_vld_i,
  output logic      in_rdy_o,
  input  err_t      in_data_i,
  input  cfg_t      cfg_i,
  output logic      out_vld_o,
  input  logic      out_rdy_i,
  output out_item_t out_data_o
);

  localparam int ST_U = 0;
  localparam int ST_P = 1;
  localparam int ST_N = 2;
  localparam int ST_LG = ST_N + LOG_BITS + 1;
  localparam int ST_GN = ST_LG + 1;
  localparam int ST_RD = ST_GN + 1;
  localparam int ST_OUT = ST_RD + 1;
  localparam int NS = ST_OUT + 1;

  typedef struct packed {
    logic        neg;
    logic [5:0]  p;
    logic [30:0] m;
    logic [15:0] f;
  } nrm_t;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;
  logic [NS-1:0] arr_q;

  logic signed [34:0] e_in [LANES];
  logic signed [15:0] gain [LANES];
  logic signed [15:0] hi [LANES];
  logic signed [15:0] lo [LANES];

  logic [35:0]        u_q [LANES];
  logic [35:0]        u_d [LANES];
  logic [LANES-1:0]   neg0_q, neg1_q;
  logic [35:0]        u1_q [LANES];
  logic [5:0]         p1_q [LANES];
  logic [5:0]         p_d [LANES];
  nrm_t               nrm_q [LOG_BITS+1][LANES];
  nrm_t               nrm_d [LANES];
  logic [65:0]        sh [LANES];
  logic [20:0]        lg_q [LANES];
  logic [20:0]        lg_d [LANES];
  logic [52:0]        lgp [LANES];
  logic [20:0]        l2 [LANES];
  logic [LANES-1:0]   neglg_q, neggn_q;
  logic signed [37:0] pr_q [LANES];
  logic signed [37:0] pr_d [LANES];
  logic signed [38:0] rs [LANES];
  logic signed [22:0] r_q [LANES];
  logic signed [22:0] c1 [LANES];
  logic signed [15:0] v [LANES];
  out_item_t          out_q, out_d;

  assign e_in[LANE_X] = in_data_i.ex;
  assign e_in[LANE_Y] = in_data_i.ey;
  assign e_in[LANE_Z] = in_data_i.ez;
  assign e_in[LANE_YAW] = in_data_i.eyaw;
  assign gain[LANE_X] = cfg_i.gain_xy[31:16];
  assign gain[LANE_Y] = cfg_i.gain_xy[15:0];
  assign gain[LANE_Z] = cfg_i.gain_z_yaw[31:16];
  assign gain[LANE_YAW] = cfg_i.gain_z_yaw[15:0];
  assign hi[LANE_X] = cfg_i.lim_xy[31:16];
  assign lo[LANE_X] = cfg_i.lim_xy[15:0];
  assign hi[LANE_Y] = cfg_i.lim_xy[31:16];
  assign lo[LANE_Y] = cfg_i.lim_xy[15:0];
  assign hi[LANE_Z] = cfg_i.lim_z[31:16];
  assign lo[LANE_Z] = cfg_i.lim_z[15:0];
  assign hi[LANE_YAW] = cfg_i.lim_yaw[31:16];
  assign lo[LANE_YAW] = cfg_i.lim_yaw[15:0];

  always_comb begin
    en[NS] = out_rdy_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_rdy_o = en[0];
  assign out_vld_o = vld_q[NS-1];
  assign out_data_o = out_q;

  // magnitude plus one, top bit position, normalize to q1.30
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      u_d[l] = e_in[l][34] ? ({1'b0, ~e_in[l]} + 36'd65537)
                           : ({1'b0, e_in[l]} + 36'd65536);
      p_d[l] = 6'd16;
      for (int j = 17; j < 36; j++) begin
        if (u_q[l][j]) p_d[l] = 6'(j);
      end
      sh[l] = {u1_q[l], 30'b0} >> p1_q[l];
      nrm_d[l].neg = neg1_q[l];
      nrm_d[l].p = p1_q[l];
      nrm_d[l].m = sh[l][30:0];
      nrm_d[l].f = '0;
    end
  end

  for (genvar k = 0; k < LOG_BITS; k++) begin : g_sq
    nrm_t        nxt [LANES];
    logic [61:0] mm [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        mm[l] = nrm_q[k][l].m * nrm_q[k][l].m;
        nxt[l] = nrm_q[k][l];
        nxt[l].f[LOG_BITS-1-k] = mm[l][61];
        nxt[l].m = mm[l][61] ? mm[l][61:31] : mm[l][60:30];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_N+k+1]) begin
        nrm_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      l2[l] = {5'(nrm_q[LOG_BITS][l].p - 6'd16), nrm_q[LOG_BITS][l].f};
      lgp[l] = 53'(l2[l]) * 53'(LOG10_2_Q32) + 53'd2147483648;
      lg_d[l] = lgp[l][52:32];
      pr_d[l] = gain[l] * $signed({1'b0, lg_q[l]});
      rs[l] = neggn_q[l] ? (~{pr_q[l][37], pr_q[l]} + 39'sd32769)
                         : ({pr_q[l][37], pr_q[l]} + 39'sd32768);
      c1[l] = (r_q[l] > 23'(hi[l])) ? 23'(hi[l]) : r_q[l];
      v[l] = (c1[l] < 23'(lo[l])) ? lo[l] : c1[l][15:0];
    end
    out_d.vel_x = v[LANE_X];
    out_d.vel_y = (v[LANE_Y] == 16'sh8000) ? 16'sh7fff : -v[LANE_Y];
    out_d.vel_z = v[LANE_Z];
    out_d.yaw_rate = v[LANE_YAW];
    out_d.arrived = arr_q[ST_RD];
    if (arr_q[ST_RD]) begin
      out_d.vel_x = '0;
      out_d.vel_y = '0;
      out_d.vel_z = '0;
      out_d.yaw_rate = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) vld_q[k] <= (k == 0) ? in_vld_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) arr_q[k] <= (k == 0) ? in_data_i.arrived : arr_q[(k == 0) ? 0 : k - 1];
    end
    if (en[ST_U]) begin
      u_q <= u_d;
      for (int l = 0; l < LANES; l++) neg0_q[l] <= e_in[l][34];
    end
    if (en[ST_P]) begin
      u1_q <= u_q;
      p1_q <= p_d;
      neg1_q <= neg0_q;
    end
    if (en[ST_N]) begin
      nrm_q[0] <= nrm_d;
    end
    if (en[ST_LG]) begin
      lg_q <= lg_d;
      for (int l = 0; l < LANES; l++) neglg_q[l] <= nrm_q[LOG_BITS][l].neg;
    end
    if (en[ST_GN]) begin
      pr_q <= pr_d;
      neggn_q <= neglg_q;
    end
    if (en[ST_RD]) begin
      for (int l = 0; l < LANES; l++) r_q[l] <= rs[l][38:16];
    end
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/log_compressed_pose_controller_top.sv =====
// pose controller top: configuration registers and the four pipeline sections
// uses lcpc_pkg, lcpc_front, lcpc_cordic, lcpc_rotate, lcpc_axis
// 44 register stages: one request per cycle throughput while the output is not stalled;
// depth set by the 16-stage cordic and the 16 squaring stages of the log
// empty stages fill while the output is stalled; stall reaches the input only
// when every stage holds a request; reset clears all valid bits and loads the register defaults
module log_compressed_pose_controller_top import lcpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t   cfg_q;
  logic   front_rdy, front_vld, cord_rdy, cord_vld, rot_rdy, rot_vld, axis_rdy;
  front_t front_data;
  cst_t   cord_data;
  err_t   rot_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_xy <= RST_GAIN;
      cfg_q.gain_z_yaw <= RST_GAIN;
      cfg_q.tol_xy <= RST_TOL_XY;
      cfg_q.tol_z_yaw <= RST_TOL_Z_YAW;
      cfg_q.lim_xy <= RST_LIM;
      cfg_q.lim_z <= RST_LIM;
      cfg_q.lim_yaw <= RST_LIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_GAIN_XY:    cfg_q.gain_xy <= cfg_data_i;
        REG_GAIN_Z_YAW: cfg_q.gain_z_yaw <= cfg_data_i;
        REG_TOL_XY:     cfg_q.tol_xy <= cfg_data_i;
        REG_TOL_Z_YAW:  cfg_q.tol_z_yaw <= cfg_data_i;
        REG_LIM_XY:     cfg_q.lim_xy <= cfg_data_i;
        REG_LIM_Z:      cfg_q.lim_z <= cfg_data_i;
        REG_LIM_YAW:    cfg_q.lim_yaw <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !front_rdy;

  lcpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_valid_i),
    .in_rdy_o   (front_rdy),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .out_vld_o  (front_vld),
    .out_rdy_i  (cord_rdy),
    .out_data_o (front_data)
  );

  lcpc_cordic u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (front_vld),
    .in_rdy_o   (cord_rdy),
    .in_data_i  (front_data),
    .out_vld_o  (cord_vld),
    .out_rdy_i  (rot_rdy),
    .out_data_o (cord_data)
  );

  lcpc_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (cord_vld),
    .in_rdy_o   (rot_rdy),
    .in_data_i  (cord_data),
    .out_vld_o  (rot_vld),
    .out_rdy_i  (axis_rdy),
    .out_data_o (rot_data)
  );

  lcpc_axis u_axis (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (rot_vld),
    .in_rdy_o   (axis_rdy),
    .in_data_i  (rot_data),
    .cfg_i      (cfg_q),
    .out_vld_o  (out_valid_o),
    .out_rdy_i  (!out_stall_i),
    .out_data_o (out_data_o)
  );

  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.arrived |->
      out_data_o.vel_x == 16'sd0 && out_data_o.vel_y == 16'sd0 &&
      out_data_o.vel_z == 16'sd0 && out_data_o.yaw_rate == 16'sd0)
    else $error("arrival result with nonzero velocity");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while pipeline can move");

  a_vel_y_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.vel_y != 16'sh8000)
    else $error("negated y command not saturated");

endmodule
